[rtl/hdt_pkg.sv]
`timescale 1ns / 1ps

package hdt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 128;
  localparam int unsigned INDEX_BASE_DEF  = 62;

  localparam logic [15:0] ENTRY_OVERHEAD = 16'd32;
  localparam logic [15:0] RESET_LIMIT    = 16'd4096;

  // operation codes on the kind field
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_RESIZE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_STATIC = 2'd1;
  localparam logic [1:0] STATUS_BEYOND = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] entry_tag;
    logic [13:0] name_len;
    logic [13:0] value_len;
    logic [7:0]  lookup_index;
    logic [15:0] new_limit;
  } hdt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_tag;
    logic [13:0] found_name_len;
    logic [13:0] found_value_len;
    logic [15:0] used_octets;
    logic [7:0]  entry_count;
  } hdt_rsp_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [13:0] name_len;
    logic [13:0] value_len;
  } entry_t;

  // octets charged for one entry
  function automatic logic [15:0] entry_charge(logic [13:0] name_len, logic [13:0] value_len);
    return ENTRY_OVERHEAD + {2'b00, name_len} + {2'b00, value_len};
  endfunction

endpackage

[rtl/hdt_store.sv]
`timescale 1ns / 1ps

module hdt_store #(
  parameter int unsigned Depth = hdt_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  hdt_pkg::entry_t     wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output hdt_pkg::entry_t     rdata_o
);
  import hdt_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hdt_ctrl.sv]
`timescale 1ns / 1ps

module hdt_ctrl #(
  parameter int unsigned MaxEntries = hdt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned IndexBase  = hdt_pkg::INDEX_BASE_DEF,
  localparam int unsigned AddrW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hdt_pkg::hdt_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hdt_pkg::hdt_rsp_t out_data_o,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output hdt_pkg::entry_t   mem_wdata_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  input  hdt_pkg::entry_t   mem_rdata_i
);
  import hdt_pkg::*;

  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned SumW = AddrW + 2;
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_EVRD = 5'b00100,
    S_LOOK = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  hdt_req_t          req_q, req_d;
  logic [15:0]       need_q, need_d;
  logic [AddrW-1:0]  newest_q, newest_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [16:0]       used_q, used_d;
  logic [15:0]       limit_q, limit_d;
  logic [1:0]        status_q, status_d;
  entry_t            found_q, found_d;
  logic              out_valid_q, out_valid_d;
  hdt_rsp_t          out_q, out_d;

  logic [AddrW-1:0]  newest_inc;
  logic [AddrW-1:0]  oldest_pos;
  logic [7:0]        look_k;
  logic [15:0]       in_need;
  logic [15:0]       rd_charge;
  logic              evict;

  // ring position k places older than the newest entry
  function automatic logic [AddrW-1:0] ring_back(logic [AddrW-1:0] pos, logic [CntW-1:0] k);
    logic [SumW-1:0] sum;
    sum = SumW'(pos) + SumW'(MaxEntries) - SumW'(k);
    if (sum >= SumW'(MaxEntries)) begin
      sum = sum - SumW'(MaxEntries);
    end
    return sum[AddrW-1:0];
  endfunction

  assign newest_inc = (newest_q == AddrW'(MaxEntries - 1)) ? '0 : newest_q + 1'b1;
  assign oldest_pos = ring_back(newest_q, count_q - 1'b1);
  assign look_k     = in_data_i.lookup_index - 8'(IndexBase);
  assign in_need    = entry_charge(in_data_i.name_len, in_data_i.value_len);
  assign rd_charge  = entry_charge(mem_rdata_i.name_len, mem_rdata_i.value_len);

  always_comb begin
    if (req_q.kind == KIND_INSERT) begin
      evict = ((count_q != '0) && ((used_q + 17'(need_q)) > 17'(limit_q)))
              || (count_q >= CntW'(MaxEntries));
    end else begin
      evict = (count_q != '0) && (used_q > 17'(limit_q));
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    need_d      = need_q;
    newest_d    = newest_q;
    count_d     = count_q;
    used_d      = used_q;
    limit_d     = limit_q;
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_raddr_o = oldest_pos;
    in_ready_o  = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          need_d   = in_need;
          status_d = STATUS_OK;
          found_d  = '0;
          case (in_data_i.kind)
            KIND_INSERT: begin
              if (in_need > limit_q) begin
                count_d = '0;
                used_d  = '0;
                state_d = S_DONE;
              end else begin
                state_d = S_CHK;
              end
            end
            KIND_LOOKUP: begin
              if (in_data_i.lookup_index < 8'(IndexBase)) begin
                status_d = STATUS_STATIC;
                state_d  = S_DONE;
              end else if (CmpW'(look_k) >= CmpW'(count_q)) begin
                status_d = STATUS_BEYOND;
                state_d  = S_DONE;
              end else begin
                mem_raddr_o = ring_back(newest_q, CntW'(look_k));
                state_d     = S_LOOK;
              end
            end
            KIND_RESIZE: begin
              limit_d = in_data_i.new_limit;
              state_d = S_CHK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CHK: begin
        if (evict) begin
          state_d = S_EVRD;
        end else begin
          if (req_q.kind == KIND_INSERT) begin
            mem_we_o = 1'b1;
            newest_d = newest_inc;
            count_d  = count_q + 1'b1;
            used_d   = used_q + 17'(need_q);
          end
          state_d = S_DONE;
        end
      end
      S_EVRD: begin
        used_d  = (17'(rd_charge) > used_q) ? '0 : used_q - 17'(rd_charge);
        count_d = count_q - 1'b1;
        state_d = S_CHK;
      end
      S_LOOK: begin
        found_d = mem_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.status          = status_q;
          out_d.found_tag       = found_q.tag;
          out_d.found_name_len  = found_q.name_len;
          out_d.found_value_len = found_q.value_len;
          out_d.used_octets     = used_q[15:0];
          out_d.entry_count     = 8'(count_q);
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_waddr_o     = newest_inc;
  assign mem_wdata_o.tag       = req_q.entry_tag;
  assign mem_wdata_o.name_len  = req_q.name_len;
  assign mem_wdata_o.value_len = req_q.value_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      newest_q    <= '0;
      count_q     <= '0;
      used_q      <= '0;
      limit_q     <= RESET_LIMIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      count_q     <= count_d;
      used_q      <= used_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    need_q   <= need_d;
    status_q <= status_d;
    found_q  <= found_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("entry count exceeds ring depth");

  a_empty_no_octets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (used_q == '0))
    else $error("octets charged with an empty table");

  a_fits_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (used_q <= 17'(limit_q)))
    else $error("table exceeds its limit between words");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("finished word not presented");

endmodule

[rtl/header_dynamic_table.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake                 Word
// in       in   in_valid_i / in_ready_o   hdt_req_t  (insert, lookup, resize)
// out      out  out_valid_o / out_ready_i hdt_rsp_t  (one per input word)
//
// Insert passes the check state; a live-entry lookup passes the memory-read state.
// Static or out-of-range lookups, oversized inserts and unused kinds skip to done.
// Each eviction reads the entry memory, then subtracts its charge; resize also checks.
// A finished word sits in the output register; the next input is taken meanwhile.
// Reset: empty table, limit 4096 octets; the entry memory needs no clearing.
// Output stalls hold the controller only when a second word finishes.

module header_dynamic_table #(
  parameter int unsigned MaxEntries = hdt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned IndexBase  = hdt_pkg::INDEX_BASE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hdt_pkg::hdt_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hdt_pkg::hdt_rsp_t out_data_o
);
  import hdt_pkg::*;

  localparam int unsigned AddrW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;

  hdt_ctrl #(
    .MaxEntries (MaxEntries),
    .IndexBase  (IndexBase)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  hdt_store #(
    .Depth (MaxEntries)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
